// ===== src/bpa_pkg.sv =====
// Shared constants and types for the bitmap page allocator.
`default_nettype none
package bpa_pkg;
  localparam int PAGE_COUNT_DEF = 1024;
  localparam int PAGE_SHIFT    = 12;
  localparam int WORD_BITS     = 8;
  localparam logic [31:0] PHYS_BASE_RST   = 32'h0010_0000;
  localparam logic [31:0] VIRT_OFFSET_RST = 32'hC000_0000;

  typedef enum logic [1:0] {
    OP_ALLOC_ONE = 2'd0,
    OP_ALLOC_PHYS = 2'd1,
    OP_ALLOC_VIRT = 2'd2,
    OP_FREE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_NOMEM = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  localparam logic CFG_PHYS_BASE = 1'b0;
  localparam logic CFG_VIRT_OFFSET = 1'b1;

  // Classified request from front to back.
  typedef struct packed {
    logic        is_free;
    logic        is_virt;
    logic        reject;     // finished without touching the bitmap
    status_t     rej_status;
    logic [20:0] count;      // pages requested (up to 2^20)
    logic [31:0] free_off;   // page_address - phys_base
  } req_t;
endpackage
`default_nettype wire

// ===== src/bpa_front.sv =====
// Front end: accept requests, round sizes, check free range and allocation size, queue work.
`default_nettype none
module bpa_front #(
  parameter int PAGE_COUNT = bpa_pkg::PAGE_COUNT_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [1:0]   in_opcode,
  input  wire logic [31:0]  in_size_bytes,
  input  wire logic [31:0]  in_page_address,
  input  wire logic [31:0]  phys_base,
  output logic              q_valid,
  input  wire logic         q_pop,
  output bpa_pkg::req_t     q_data
);
  localparam logic [32:0] SPAN = 33'(PAGE_COUNT) << bpa_pkg::PAGE_SHIFT;

  // Two-entry queue
  bpa_pkg::req_t q_mem_r [2];
  logic q_wp_r, q_rp_r;
  logic [1:0] q_cnt_r;
  bpa_pkg::req_t req;
  logic push;
  logic [32:0] rounded;
  logic [32:0] diff;

  assign in_stall = (q_cnt_r == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (q_cnt_r != 2'd0);
  assign q_data = q_mem_r[q_rp_r];

  // Classify the incoming transaction
  always_comb begin
    rounded = {1'b0, in_size_bytes} + 33'd4095;
    diff = {1'b0, in_page_address} - {1'b0, phys_base};
    req = '0;
    req.count = rounded[32:12];
    req.free_off = diff[31:0];
    req.rej_status = bpa_pkg::ST_NOMEM;
    unique case (bpa_pkg::op_t'(in_opcode))
      bpa_pkg::OP_ALLOC_ONE: begin
        req.count = 21'd1;
      end
      bpa_pkg::OP_ALLOC_PHYS: begin
        req.reject = (in_size_bytes == 32'd0) || (req.count > 21'(PAGE_COUNT));
      end
      bpa_pkg::OP_ALLOC_VIRT: begin
        req.is_virt = 1'b1;
        req.reject = (in_size_bytes == 32'd0) || (req.count > 21'(PAGE_COUNT));
      end
      bpa_pkg::OP_FREE: begin
        req.is_free = 1'b1;
        req.count = 21'd0;
        req.rej_status = bpa_pkg::ST_RANGE;
        req.reject = diff[32] || (diff >= SPAN);
      end
      default: ;
    endcase
  end

  // Hold queue storage
  always_ff @(posedge clk) begin
    if (push) q_mem_r[q_wp_r] <= req;
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wp_r <= 1'b0;
      q_rp_r <= 1'b0;
      q_cnt_r <= 2'd0;
    end else begin
      if (push) q_wp_r <= ~q_wp_r;
      if (q_pop) q_rp_r <= ~q_rp_r;
      q_cnt_r <= q_cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule
`default_nettype wire

// ===== src/bpa_back.sv =====
// Back end: bitmap memory, first-fit scan, marking and free.
`default_nettype none
module bpa_back #(
  parameter int PAGE_COUNT = bpa_pkg::PAGE_COUNT_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         q_valid,
  output logic              q_pop,
  input  bpa_pkg::req_t     q_data,
  input  wire logic [31:0]  phys_base,
  input  wire logic [31:0]  virt_offset,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [31:0]       out_result_address,
  output logic [1:0]        out_status
);
  localparam int WB = bpa_pkg::WORD_BITS;
  localparam int NW = (PAGE_COUNT + WB - 1) / WB;
  localparam int AW = (NW > 1) ? $clog2(NW) : 1;
  localparam int PW = $clog2(PAGE_COUNT + 1);
  localparam int CW = $clog2(NW + 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD, S_SCAN, S_MRD, S_MARK, S_FREE, S_ADDR, S_DONE
  } state_t;

  state_t state_r;
  logic [WB-1:0] mem [NW];
  logic [WB-1:0] rd_data_r;
  logic [CW-1:0] word_r;      // current word index (0 to NW-1)
  logic [PW-1:0] start_r;     // candidate run start
  logic [PW-1:0] run_r;       // free pages in run so far
  logic [PW-1:0] need_r;
  logic [PW-1:0] mark_r;      // next page to mark
  logic          is_virt_r;
  logic [31:0]   addr_r;
  logic [1:0]    status_r;
  logic [31:0]   off_r;

  // Walk one word: up to eight dependent narrow steps
  logic [PW-1:0] s_start, s_run;
  logic          s_found;
  logic [PW-1:0] pg;
  always_comb begin
    s_start = start_r;
    s_run = run_r;
    s_found = 1'b0;
    for (int b = 0; b < WB; b++) begin
      pg = PW'(word_r) * PW'(WB) + PW'(b);
      if (!s_found && (pg < PW'(PAGE_COUNT))) begin
        if (rd_data_r[b]) begin
          s_run = '0;
          s_start = pg + PW'(1);
        end else begin
          s_run = s_run + PW'(1);
          if (s_run == need_r) s_found = 1'b1;
        end
      end
    end
  end

  logic [PW-1:0] mark_end;
  assign mark_end = start_r + need_r;
  logic [AW-1:0] mark_word;
  assign mark_word = AW'(mark_r / PW'(WB));
  logic [$clog2(WB)-1:0] mark_bit;
  assign mark_bit = mark_r[$clog2(WB)-1:0];
  logic [PW-1:0] free_pg;
  assign free_pg = PW'(off_r >> bpa_pkg::PAGE_SHIFT);

  assign q_pop = (state_r == S_IDLE) && q_valid;
  assign out_valid = (state_r == S_DONE);
  assign out_result_address = addr_r;
  assign out_status = status_r;

  // Hold bitmap memory: one read and one write port
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [WB-1:0] wr_data;
  logic [AW-1:0] rd_addr;
  always_comb begin
    wr_en = 1'b0;
    wr_addr = mark_word;
    wr_data = rd_data_r;
    rd_addr = AW'(word_r);
    unique case (state_r)
      S_CLEAR: begin
        wr_en = 1'b1;
        wr_addr = AW'(word_r);
        wr_data = '0;
      end
      S_MRD: begin
        rd_addr = mark_word;
      end
      S_MARK: begin
        wr_en = 1'b1;
        wr_data = rd_data_r | (WB'(1) << mark_bit);
      end
      S_FREE: begin
        wr_en = 1'b1;
        wr_addr = AW'(free_pg / PW'(WB));
        wr_data = rd_data_r & ~(WB'(1) << free_pg[$clog2(WB)-1:0]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  // Sequence each request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      word_r <= '0;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          if (word_r == CW'(NW - 1)) begin
            word_r <= '0;
            state_r <= S_IDLE;
          end else begin
            word_r <= word_r + CW'(1);
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            is_virt_r <= q_data.is_virt;
            need_r <= PW'(q_data.count);
            off_r <= q_data.free_off;
            start_r <= '0;
            run_r <= '0;
            addr_r <= '0;
            status_r <= q_data.reject ? q_data.rej_status : bpa_pkg::ST_OK;
            if (q_data.reject) begin
              state_r <= S_DONE;
            end else if (q_data.is_free) begin
              word_r <= CW'(PW'(q_data.free_off >> bpa_pkg::PAGE_SHIFT) / PW'(WB));
              state_r <= S_RD;
            end else begin
              word_r <= '0;
              state_r <= S_RD;
            end
          end
        end
        S_RD: begin
          // memory read of word_r in flight; a free carries no page count
          state_r <= (need_r == '0) ? S_FREE : S_SCAN;
        end
        S_SCAN: begin
          start_r <= s_start;
          run_r <= s_run;
          if (s_found) begin
            mark_r <= s_start;
            state_r <= S_MRD;
          end else if (word_r == CW'(NW - 1)) begin
            status_r <= bpa_pkg::ST_NOMEM;
            state_r <= S_DONE;
          end else begin
            word_r <= word_r + CW'(1);
            state_r <= S_RD;
          end
        end
        S_MRD: begin
          // read the word that holds the next page to mark
          state_r <= S_MARK;
        end
        S_MARK: begin
          // write the fresh word back with one more bit set
          mark_r <= mark_r + PW'(1);
          if (mark_r + PW'(1) == mark_end) state_r <= S_ADDR;
          else state_r <= S_MRD;
        end
        S_FREE: begin
          state_r <= S_DONE;
        end
        S_ADDR: begin
          addr_r <= phys_base + ({{(32-PW){1'b0}}, start_r} << bpa_pkg::PAGE_SHIFT)
                    + (is_virt_r ? virt_offset : 32'd0);
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_stall) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== src/bitmap_page_allocator.sv =====
// Top level of the bitmap page allocator.
//
//  channel  direction  handshake          payload
//  in_      input      in_valid/in_stall  opcode, size_bytes, page_address
//  out_     output     out_valid/out_stall result_address, status
//  cfg_     input      cfg_wr_en          cfg_index, cfg_wdata
//
// From the queue pop, allocation reads and scans each 8-page bitmap word
// in turn, reads and writes back the word of each marked page, then forms
// the address; a free reads the word and clears its bit, and a rejected
// request goes straight to the result. After reset a clearing pass writes
// every bitmap word before the first request is taken. A two-entry queue
// lets requests enter while the back end is busy or stalled.
`default_nettype none
module bitmap_page_allocator #(
  parameter int PAGE_COUNT = bpa_pkg::PAGE_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [31:0] in_size_bytes,
  input  wire logic [31:0] in_page_address,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_result_address,
  output logic [1:0]       out_status,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_wdata
);
  logic [31:0] phys_base_r, virt_offset_r;
  logic q_valid, q_pop;
  bpa_pkg::req_t q_data;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phys_base_r <= bpa_pkg::PHYS_BASE_RST;
      virt_offset_r <= bpa_pkg::VIRT_OFFSET_RST;
    end else if (cfg_wr_en) begin
      if (cfg_index == bpa_pkg::CFG_PHYS_BASE) phys_base_r <= cfg_wdata;
      else virt_offset_r <= cfg_wdata;
    end
  end

  bpa_front #(.PAGE_COUNT(PAGE_COUNT)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_opcode, .in_size_bytes,
    .in_page_address, .phys_base(phys_base_r), .q_valid, .q_pop, .q_data
  );

  bpa_back #(.PAGE_COUNT(PAGE_COUNT)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_data, .phys_base(phys_base_r),
    .virt_offset(virt_offset_r), .out_valid, .out_stall, .out_result_address,
    .out_status
  );
endmodule
`default_nettype wire
